[design/sdrd_pkg.sv]
// ----------------------------------------------------------------------------
// sdrd_pkg
// Types and constants shared by the SD SPI block read receiver.
// ----------------------------------------------------------------------------
package sdrd_pkg;

    localparam int POLL_W    = 9;
    localparam int LIMIT_W   = 9;
    localparam int CFG_IDX_W = 1;
    localparam int LEN_IN_W  = 10;

    localparam logic [POLL_W:0] LIMIT_MAX   = 10'd256;
    localparam logic [7:0]      RX_FILL     = 8'hFF;
    localparam logic [7:0]      DATA_TOKEN  = 8'hFE;
    localparam logic [7:0]      R1_READY    = 8'h00;
    localparam int              R1_BUSY_BIT = 7;
    localparam logic [1:0]      CRC_BYTES   = 2'd2;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_BYTE  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RESP_LIMIT  = 1'b0,
        CFG_TOKEN_LIMIT = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_R1    = 3'd1,
        PH_TOKEN = 3'd2,
        PH_DATA  = 3'd3,
        PH_CRC   = 3'd4,
        PH_TRAIL = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SPI       = 3'd1,
        ST_TIMEOUT   = 3'd2,
        ST_BAD_R1    = 3'd3,
        ST_BAD_TOKEN = 3'd4
    } status_t;

    typedef struct packed {
        phase_t            phase;
        logic [POLL_W-1:0] poll_count;
        logic [1:0]        crc_skip_left;
        status_t           result_code;
    } ctl_t;

    typedef struct packed {
        logic       data_valid;
        logic [7:0] data_byte;
        logic       want_more;
        logic       done_res;
        status_t    status;
    } rslt_t;

    function automatic logic [POLL_W:0] eff_limit(input logic [LIMIT_W-1:0] v);
        if (v == '0 || {1'b0, v} > LIMIT_MAX) begin
            return LIMIT_MAX;
        end
        return {1'b0, v};
    endfunction

endpackage

[design/sdrd_step.sv]
// ----------------------------------------------------------------------------
// sdrd_step
// Next-state and result logic for one transaction of the block read receiver.
// ----------------------------------------------------------------------------
module sdrd_step #(
    parameter  int MAX_BLOCK_BYTES = 512,
    localparam int HELD_FULL       = $clog2(MAX_BLOCK_BYTES + 1),
    localparam int HELD_W          = (HELD_FULL < sdrd_pkg::LEN_IN_W) ? HELD_FULL
                                                                      : sdrd_pkg::LEN_IN_W
) (
    input  sdrd_pkg::ctl_t                    ctl,
    input  logic [HELD_W-1:0]                 bytes_done,
    input  logic [HELD_W-1:0]                 length_held,
    input  logic [sdrd_pkg::LIMIT_W-1:0]      resp_limit,
    input  logic [sdrd_pkg::LIMIT_W-1:0]      token_limit,
    input  logic                              action,
    input  logic [sdrd_pkg::LEN_IN_W-1:0]     block_length,
    input  logic [7:0]                        rx_byte,
    input  logic                              link_error,
    output sdrd_pkg::ctl_t                    ctl_next,
    output logic [HELD_W-1:0]                 bytes_done_next,
    output logic [HELD_W-1:0]                 length_held_next,
    output sdrd_pkg::rslt_t                   rslt
);
    import sdrd_pkg::*;

    logic [POLL_W:0] poll_inc;
    logic [1:0]      crc_dec;
    logic [HELD_W:0] bytes_inc;

    assign poll_inc  = {1'b0, ctl.poll_count} + 1'b1;
    assign crc_dec   = ctl.crc_skip_left - 2'd1;
    assign bytes_inc = {1'b0, bytes_done} + 1'b1;

    always_comb begin
        ctl_next         = ctl;
        bytes_done_next  = bytes_done;
        length_held_next = length_held;
        rslt             = '0;
        if (action == ACT_START) begin
            if (int'(block_length) > MAX_BLOCK_BYTES) begin
                length_held_next = HELD_W'(MAX_BLOCK_BYTES);
            end else begin
                length_held_next = HELD_W'(block_length);
            end
            bytes_done_next       = '0;
            ctl_next.poll_count   = '0;
            ctl_next.crc_skip_left = '0;
            ctl_next.result_code  = ST_OK;
            ctl_next.phase        = PH_R1;
        end else begin
            case (ctl.phase)
                PH_R1: begin
                    ctl_next.poll_count = poll_inc[POLL_W-1:0];
                    if (link_error) begin
                        ctl_next.result_code = ST_SPI;
                        ctl_next.phase       = PH_TRAIL;
                    end else if (poll_inc >= eff_limit(resp_limit)) begin
                        ctl_next.result_code = ST_TIMEOUT;
                        ctl_next.phase       = PH_TRAIL;
                    end else if (rx_byte[R1_BUSY_BIT]) begin
                        ctl_next.phase = PH_R1;
                    end else if (rx_byte == R1_READY) begin
                        ctl_next.poll_count = '0;
                        ctl_next.phase      = PH_TOKEN;
                    end else begin
                        ctl_next.result_code = ST_BAD_R1;
                        ctl_next.phase       = PH_TRAIL;
                    end
                end
                PH_TOKEN: begin
                    ctl_next.poll_count = poll_inc[POLL_W-1:0];
                    if (link_error) begin
                        ctl_next.result_code = ST_SPI;
                        ctl_next.phase       = PH_TRAIL;
                    end else if (poll_inc >= eff_limit(token_limit)) begin
                        ctl_next.result_code = ST_TIMEOUT;
                        ctl_next.phase       = PH_TRAIL;
                    end else if (rx_byte == RX_FILL) begin
                        ctl_next.phase = PH_TOKEN;
                    end else if (rx_byte == DATA_TOKEN) begin
                        bytes_done_next = '0;
                        if (length_held == '0) begin
                            ctl_next.crc_skip_left = CRC_BYTES;
                            ctl_next.phase         = PH_CRC;
                        end else begin
                            ctl_next.phase = PH_DATA;
                        end
                    end else begin
                        ctl_next.result_code = ST_BAD_TOKEN;
                        ctl_next.phase       = PH_TRAIL;
                    end
                end
                PH_DATA: begin
                    rslt.data_valid = 1'b1;
                    rslt.data_byte  = rx_byte;
                    bytes_done_next = bytes_inc[HELD_W-1:0];
                    if (bytes_inc >= {1'b0, length_held}) begin
                        ctl_next.crc_skip_left = CRC_BYTES;
                        ctl_next.phase         = PH_CRC;
                    end
                end
                PH_CRC: begin
                    ctl_next.crc_skip_left = crc_dec;
                    if (crc_dec == 2'd0) begin
                        ctl_next.phase = PH_TRAIL;
                    end
                end
                PH_TRAIL: begin
                    rslt.done_res  = 1'b1;
                    rslt.status    = ctl.result_code;
                    ctl_next.phase = PH_IDLE;
                end
                default: begin
                    ctl_next.phase = PH_IDLE;
                end
            endcase
        end
        rslt.want_more = (ctl_next.phase != PH_IDLE);
    end

endmodule

[design/sd_spi_block_read_receiver.sv]
// ----------------------------------------------------------------------------
// sd_spi_block_read_receiver
// Parses the SD card SPI reply to a single-block read: R1 poll, data token,
// payload, CRC and trailing byte, then reports done with a status.
//
//   channel | ports                         | direction
//   --------+-------------------------------+----------
//   input   | s_valid/s_ready + item fields | in
//   result  | m_valid/m_ready + result flds | out
//   config  | cfg_valid/cfg_ready, idx/data | in
//
// One transaction per cycle while the result buffer has room: the phase step is short
// combinational logic between the state registers and a two-entry result buffer.
// Each input transaction yields one result, registered in the output register or skid entry.
// Synchronous active-low reset; the poll limits reset to 256.
// The input side stalls only while both result entries are full.
// ----------------------------------------------------------------------------
module sd_spi_block_read_receiver #(
    parameter int MAX_BLOCK_BYTES = 512
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sdrd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sdrd_pkg::LIMIT_W-1:0]      cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_action,
    input  logic [sdrd_pkg::LEN_IN_W-1:0]     s_block_length,
    input  logic [7:0]                        s_rx_byte,
    input  logic                              s_link_error,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_data_valid,
    output logic [7:0]                        m_data_byte,
    output logic                              m_want_more,
    output logic                              m_done_res,
    output logic [2:0]                        m_status
);
    import sdrd_pkg::*;

    localparam int HELD_FULL = $clog2(MAX_BLOCK_BYTES + 1);
    localparam int HELD_W    = (HELD_FULL < LEN_IN_W) ? HELD_FULL : LEN_IN_W;

    logic [LIMIT_W-1:0] resp_limit_reg;
    logic [LIMIT_W-1:0] token_limit_reg;

    ctl_t               ctl_reg;
    ctl_t               ctl_next;
    logic [HELD_W-1:0]  bytes_done_reg;
    logic [HELD_W-1:0]  bytes_done_next;
    logic [HELD_W-1:0]  length_held_reg;
    logic [HELD_W-1:0]  length_held_next;
    rslt_t              rslt_next;

    rslt_t              out_reg;
    logic               out_valid_reg;
    rslt_t              skid_reg;
    logic               skid_valid_reg;

    logic               push;
    logic               pop;

    assign cfg_ready = 1'b1;
    assign s_ready   = !skid_valid_reg;
    assign push      = s_valid && s_ready;
    assign pop       = out_valid_reg && m_ready;

    sdrd_step #(
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
    ) u_step (
        .ctl              (ctl_reg),
        .bytes_done       (bytes_done_reg),
        .length_held      (length_held_reg),
        .resp_limit       (resp_limit_reg),
        .token_limit      (token_limit_reg),
        .action           (s_action),
        .block_length     (s_block_length),
        .rx_byte          (s_rx_byte),
        .link_error       (s_link_error),
        .ctl_next         (ctl_next),
        .bytes_done_next  (bytes_done_next),
        .length_held_next (length_held_next),
        .rslt             (rslt_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            resp_limit_reg  <= LIMIT_W'(LIMIT_MAX);
            token_limit_reg <= LIMIT_W'(LIMIT_MAX);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                CFG_RESP_LIMIT:  resp_limit_reg  <= cfg_data;
                CFG_TOKEN_LIMIT: token_limit_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg         <= '{phase: PH_IDLE, poll_count: '0, crc_skip_left: '0,
                                 result_code: ST_OK};
            bytes_done_reg  <= '0;
            length_held_reg <= '0;
        end else if (push) begin
            ctl_reg         <= ctl_next;
            bytes_done_reg  <= bytes_done_next;
            length_held_reg <= length_held_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (push) begin
                out_reg <= rslt_next;
            end
        end else if (push) begin
            skid_reg <= rslt_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_data_valid = out_reg.data_valid;
    assign m_data_byte  = out_reg.data_byte;
    assign m_want_more  = out_reg.want_more;
    assign m_done_res   = out_reg.done_res;
    assign m_status     = out_reg.status;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while result register empty");

    a_done_ends_read: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.done_res |-> !out_reg.want_more)
        else $error("done result still asks for more bytes");

    a_status_only_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_reg.done_res |-> out_reg.status == ST_OK)
        else $error("status reported without done");

    a_start_arms_r1: assert property (@(posedge aclk) disable iff (!aresetn)
        push && s_action == ACT_START |=> ctl_reg.phase == PH_R1)
        else $error("start transaction did not arm R1 poll");
`endif

endmodule
